// ----- hdl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ps2kcp_pkg.sv -----
package ps2kcp_pkg;

   localparam int KEY_CODES_DEF = 256;

   // request kinds
   localparam logic [1:0] REQ_HOST   = 2'd0;
   localparam logic [1:0] REQ_BLINK  = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   // host commands
   localparam logic [7:0] CMD_SET_LEDS  = 8'hed;
   localparam logic [7:0] CMD_ECHO      = 8'hee;
   localparam logic [7:0] CMD_CODE_SET  = 8'hf0;
   localparam logic [7:0] CMD_READ_ID   = 8'hf2;
   localparam logic [7:0] CMD_TYPEMATIC = 8'hf3;
   localparam logic [7:0] CMD_ENABLE    = 8'hf4;
   localparam logic [7:0] CMD_DISABLE   = 8'hf5;
   localparam logic [7:0] CMD_DEFAULTS  = 8'hf6;
   localparam logic [7:0] CMD_ALL_TYPE  = 8'hf7;
   localparam logic [7:0] CMD_ALL_MB    = 8'hf8;
   localparam logic [7:0] CMD_ALL_MO    = 8'hf9;
   localparam logic [7:0] CMD_ALL_MBT   = 8'hfa;
   localparam logic [7:0] CMD_KEY_TYPE  = 8'hfb;
   localparam logic [7:0] CMD_KEY_MB    = 8'hfc;
   localparam logic [7:0] CMD_KEY_MO    = 8'hfd;
   localparam logic [7:0] CMD_RESEND    = 8'hfe;
   localparam logic [7:0] CMD_RESET     = 8'hff;

   // reply bytes
   localparam logic [7:0] RPL_ACK    = 8'hfa;
   localparam logic [7:0] RPL_RESEND = 8'hfe;
   localparam logic [7:0] RPL_ECHO   = 8'hee;
   localparam logic [7:0] RPL_ID0    = 8'hab;
   localparam logic [7:0] RPL_ID1    = 8'h83;
   localparam logic [7:0] RPL_BAT_OK = 8'haa;

   // per-key flags: bit0 make, bit1 break, bit2 typematic
   localparam logic [2:0] FLAGS_TYPE = 3'b100;
   localparam logic [2:0] FLAGS_MB   = 3'b011;
   localparam logic [2:0] FLAGS_MO   = 3'b001;
   localparam logic [2:0] FLAGS_ALL  = 3'b111;

   // typematic byte: delay index in bits 6:5, rate index in bits 4:0
   localparam logic [6:0] TYP_DEFAULT = 7'b01_00000;

   typedef enum logic [2:0] {
      PEND_NONE  = 3'd0,
      PEND_LEDS  = 3'd1,
      PEND_SET   = 3'd2,
      PEND_RATE  = 3'd3,
      PEND_KTYPE = 3'd4,
      PEND_KMB   = 3'd5,
      PEND_KMO   = 3'd6
   } pend_type;

   // outcome of one host byte
   typedef struct packed {
      logic [1:0] nrep;
      logic [7:0] rep0;
      logic [7:0] rep1;
      logic [7:0] rep2;
      logic       clr;
      pend_type   pend;
      logic       led_we;
      logic [2:0] led_val;
      logic       set_we;
      logic [1:0] set_val;
      logic       typ_we;
      logic [6:0] typ_val;
      logic       scan_we;
      logic       scan_val;
      logic       blink_set;
      logic       key_we;
      logic [2:0] key_val;
      logic       fill_en;
      logic [2:0] fill_val;
   } dec_type;

   localparam logic [8:0] RATE_TAB [32] = '{
      9'd33,  9'd37,  9'd42,  9'd46,  9'd50,  9'd54,  9'd58,  9'd63,
      9'd67,  9'd75,  9'd83,  9'd92,  9'd100, 9'd109, 9'd118, 9'd125,
      9'd133, 9'd149, 9'd167, 9'd182, 9'd200, 9'd217, 9'd233, 9'd250,
      9'd270, 9'd303, 9'd333, 9'd370, 9'd400, 9'd435, 9'd476, 9'd500
   };

   function automatic logic [9:0] delay_ms(input logic [1:0] idx);
      logic [9:0] ms;
      case (idx)
         2'd0: ms = 10'd250;
         2'd1: ms = 10'd500;
         2'd2: ms = 10'd750;
         default: ms = 10'd1000;
      endcase
      return ms;
   endfunction

endpackage

// ----- hdl/ps2kcp_key_ram.sv -----
module ps2kcp_key_ram #(
   parameter int DEPTH = ps2kcp_pkg::KEY_CODES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [2:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [2:0]    rdata
);

   logic [2:0] mem [DEPTH];
   logic [2:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/ps2kcp_decode.sv -----
module ps2kcp_decode (
   input  logic                 [7:0] byte_i,
   input  ps2kcp_pkg::pend_type       pend_i,
   input  logic                 [1:0] en_sets,
   input  logic                 [1:0] cur_set,
   output ps2kcp_pkg::dec_type        dec
);

   logic is_cmd;
   logic set_bad;

   assign is_cmd = byte_i[7] && (pend_i != ps2kcp_pkg::PEND_KTYPE) &&
                   (pend_i != ps2kcp_pkg::PEND_KMB) && (pend_i != ps2kcp_pkg::PEND_KMO);

   assign set_bad = (byte_i > 8'd3) || ((byte_i == 8'd2) && !en_sets[0]) ||
                    ((byte_i == 8'd3) && !en_sets[1]);

   always_comb begin
      dec = '0;
      dec.pend = pend_i;
      if (is_cmd) begin
         dec.pend = ps2kcp_pkg::PEND_NONE;
         dec.nrep = 2'd1;
         dec.rep0 = ps2kcp_pkg::RPL_ACK;
         case (byte_i)
            ps2kcp_pkg::CMD_SET_LEDS: begin
               dec.pend = ps2kcp_pkg::PEND_LEDS;
            end
            ps2kcp_pkg::CMD_TYPEMATIC: begin
               dec.pend = ps2kcp_pkg::PEND_RATE;
            end
            ps2kcp_pkg::CMD_CODE_SET: begin
               dec.clr  = 1'b1;
               dec.pend = ps2kcp_pkg::PEND_SET;
            end
            ps2kcp_pkg::CMD_KEY_TYPE: begin
               dec.clr  = 1'b1;
               dec.pend = ps2kcp_pkg::PEND_KTYPE;
            end
            ps2kcp_pkg::CMD_KEY_MB: begin
               dec.clr  = 1'b1;
               dec.pend = ps2kcp_pkg::PEND_KMB;
            end
            ps2kcp_pkg::CMD_KEY_MO: begin
               dec.clr  = 1'b1;
               dec.pend = ps2kcp_pkg::PEND_KMO;
            end
            ps2kcp_pkg::CMD_ECHO: begin
               dec.rep0 = ps2kcp_pkg::RPL_ECHO;
            end
            ps2kcp_pkg::CMD_READ_ID: begin
               dec.nrep = 2'd3;
               dec.rep1 = ps2kcp_pkg::RPL_ID0;
               dec.rep2 = ps2kcp_pkg::RPL_ID1;
            end
            ps2kcp_pkg::CMD_ENABLE: begin
               dec.clr      = 1'b1;
               dec.scan_we  = 1'b1;
               dec.scan_val = 1'b1;
            end
            ps2kcp_pkg::CMD_DISABLE, ps2kcp_pkg::CMD_DEFAULTS, ps2kcp_pkg::CMD_RESET: begin
               // restore defaults
               dec.clr      = 1'b1;
               dec.typ_we   = 1'b1;
               dec.typ_val  = ps2kcp_pkg::TYP_DEFAULT;
               dec.fill_en  = 1'b1;
               dec.fill_val = ps2kcp_pkg::FLAGS_ALL;
               dec.set_we   = 1'b1;
               dec.set_val  = en_sets[0] ? 2'd2 : 2'd1;
               dec.scan_we  = 1'b1;
               dec.scan_val = (byte_i != ps2kcp_pkg::CMD_DISABLE);
               if (byte_i == ps2kcp_pkg::CMD_RESET) begin
                  dec.led_we    = 1'b1;
                  dec.led_val   = 3'd0;
                  dec.blink_set = 1'b1;
                  dec.nrep      = 2'd2;
                  dec.rep1      = ps2kcp_pkg::RPL_BAT_OK;
               end
            end
            ps2kcp_pkg::CMD_ALL_TYPE: begin
               dec.clr      = 1'b1;
               dec.fill_en  = 1'b1;
               dec.fill_val = ps2kcp_pkg::FLAGS_TYPE;
            end
            ps2kcp_pkg::CMD_ALL_MB: begin
               dec.clr      = 1'b1;
               dec.fill_en  = 1'b1;
               dec.fill_val = ps2kcp_pkg::FLAGS_MB;
            end
            ps2kcp_pkg::CMD_ALL_MO: begin
               dec.clr      = 1'b1;
               dec.fill_en  = 1'b1;
               dec.fill_val = ps2kcp_pkg::FLAGS_MO;
            end
            ps2kcp_pkg::CMD_ALL_MBT: begin
               dec.clr      = 1'b1;
               dec.fill_en  = 1'b1;
               dec.fill_val = ps2kcp_pkg::FLAGS_ALL;
            end
            ps2kcp_pkg::CMD_RESEND: begin
               dec.rep0 = ps2kcp_pkg::RPL_ACK;
            end
            default: begin
               dec.rep0 = ps2kcp_pkg::RPL_RESEND;
            end
         endcase
      end else if (pend_i != ps2kcp_pkg::PEND_NONE) begin
         dec.pend = ps2kcp_pkg::PEND_NONE;
         dec.nrep = 2'd1;
         dec.rep0 = ps2kcp_pkg::RPL_ACK;
         case (pend_i)
            ps2kcp_pkg::PEND_LEDS: begin
               dec.led_we  = 1'b1;
               dec.led_val = byte_i[2:0];
            end
            ps2kcp_pkg::PEND_SET: begin
               if (byte_i == 8'd0) begin
                  dec.nrep = 2'd2;
                  dec.rep1 = {6'd0, cur_set};
               end else if (set_bad) begin
                  dec.pend = ps2kcp_pkg::PEND_SET;
                  dec.rep0 = ps2kcp_pkg::RPL_RESEND;
               end else begin
                  dec.set_we  = 1'b1;
                  dec.set_val = byte_i[1:0];
                  dec.clr     = 1'b1;
               end
            end
            ps2kcp_pkg::PEND_RATE: begin
               dec.typ_we  = 1'b1;
               dec.typ_val = byte_i[6:0];
            end
            ps2kcp_pkg::PEND_KTYPE: begin
               dec.clr     = 1'b1;
               dec.key_we  = 1'b1;
               dec.key_val = ps2kcp_pkg::FLAGS_TYPE;
            end
            ps2kcp_pkg::PEND_KMB: begin
               dec.clr     = 1'b1;
               dec.key_we  = 1'b1;
               dec.key_val = ps2kcp_pkg::FLAGS_MB;
            end
            ps2kcp_pkg::PEND_KMO: begin
               dec.clr     = 1'b1;
               dec.key_we  = 1'b1;
               dec.key_val = ps2kcp_pkg::FLAGS_MO;
            end
            default: begin
               dec.nrep = 2'd0;
               dec.rep0 = 8'd0;
            end
         endcase
      end
   end

endmodule

// ----- hdl/ps2_keyboard_command_processor_unit.sv -----
// keyboard-side ps/2 command processor
//
// input stream (req_*): req_tuser is the request kind (host byte, led blink
// expiry, per-key flag lookup), req_tdata the host byte or key code.
// result stream (rsp_*): one transfer per reply byte, or a single transfer
// with rsp_tuser low when the request makes no reply; rsp_tlast marks the
// final transfer of a request. every transfer carries the settings as they
// stand after the request.
// csr port: enabled_sets at byte address 0; the user must write it only while idle, the block does not enforce it.
//
// one request at a time: req_tready is high only when the block is idle.
// a request is accepted in idle; a lookup then passes the read state for
// the key table read, and the result transfers go out in the send state.
// a stalled rsp_tready holds the current transfer and no new request is
// taken until the last one is gone. commands that set every key's flags
// (all-keys commands, defaults, disable, reset) add a write sweep through
// every key table entry after their results. after reset the same sweep
// loads every key with all flags on, so req_tready rises only once that
// sweep is done.
module ps2_keyboard_command_processor_unit #(
   parameter int KEY_CODES = ps2kcp_pkg::KEY_CODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [1:0]  req_tuser,   // req_type
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // reply_byte[7:0], buffer_clear[8], scanning[9], led_bits[12:10],
   // active_set[14:13], typematic_delay_ms[24:15], typematic_interval[33:25],
   // key_make_on[34], key_break_on[35], key_repeat_on[36], zero[39:37]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // reply_valid
   output logic        rsp_tlast,   // last
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(KEY_CODES);

   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   ps2kcp_pkg::pend_type pend_ff, pend_in;
   logic [1:0]           set_ff, set_in;
   logic [2:0]           led_ff, led_in;
   logic                 blink_ff, blink_in;
   logic                 scan_ff, scan_in;
   logic [6:0]           typ_ff, typ_in;
   logic [1:0]           en_sets_ff, en_sets_in;
   logic [2:0]           fill_ff, fill_in;
   logic                 fill_pend_ff, fill_pend_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic                 key_ok_ff, key_ok_in;
   logic [7:0]           rep0_ff, rep0_in;
   logic [7:0]           rep1_ff, rep1_in;
   logic [7:0]           rep2_ff, rep2_in;
   logic [1:0]           nrep_ff, nrep_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 clr_ff, clr_in;
   logic [2:0]           kf_ff, kf_in;

   ps2kcp_pkg::dec_type  dec;
   logic                 accept;
   logic                 last_res;
   logic                 key_in_range;
   logic                 sweep_last;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [2:0]           ram_wdata;
   logic                 ram_re;
   logic [2:0]           ram_rdata;
   logic [7:0]           reply;
   logic                 csr_wr;

   // command decode against the current settings
   ps2kcp_decode u_decode (
      .byte_i  (req_tdata),
      .pend_i  (pend_ff),
      .en_sets (en_sets_ff),
      .cur_set (set_ff),
      .dec     (dec)
   );

   // per-key set-3 flags
   ps2kcp_key_ram #(
      .DEPTH (KEY_CODES),
      .AW    (AW)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (req_tdata[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign key_in_range = ({1'b0, req_tdata} < 9'(KEY_CODES));
   assign sweep_last   = (sweep_ff == AW'(KEY_CODES - 1));
   assign last_res     = (nrep_ff == 2'd0) || (idx_ff == (nrep_ff - 2'd1));

   // key table port: sweep owns it, else single-key writes and lookups.
   // one request in flight, so a lookup never meets a write to its entry
   assign ram_we    = (state_ff == ST_SWEEP) ||
                      (accept && (req_tuser == ps2kcp_pkg::REQ_HOST) && dec.key_we &&
                       key_in_range);
   assign ram_waddr = (state_ff == ST_SWEEP) ? sweep_ff : req_tdata[AW-1:0];
   assign ram_wdata = (state_ff == ST_SWEEP) ? fill_ff : dec.key_val;
   assign ram_re    = accept && (req_tuser == ps2kcp_pkg::REQ_LOOKUP);

   // csr access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {30'd0, en_sets_ff};

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      set_in       = set_ff;
      led_in       = led_ff;
      blink_in     = blink_ff;
      scan_in      = scan_ff;
      typ_in       = typ_ff;
      en_sets_in   = en_sets_ff;
      fill_in      = fill_ff;
      fill_pend_in = fill_pend_ff;
      sweep_in     = sweep_ff;
      key_ok_in    = key_ok_ff;
      rep0_in      = rep0_ff;
      rep1_in      = rep1_ff;
      rep2_in      = rep2_ff;
      nrep_in      = nrep_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      kf_in        = kf_ff;

      if (csr_wr && !csr_paddr[2]) begin
         en_sets_in = csr_pwdata[1:0];
      end

      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_last) begin
               sweep_in     = '0;
               fill_pend_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               // default: single transfer with no reply
               rep0_in = 8'd0;
               rep1_in = 8'd0;
               rep2_in = 8'd0;
               nrep_in = 2'd0;
               idx_in  = 2'd0;
               clr_in  = 1'b0;
               kf_in   = 3'd0;
               state_in = ST_SEND;
               case (req_tuser)
                  ps2kcp_pkg::REQ_HOST: begin
                     rep0_in = dec.rep0;
                     rep1_in = dec.rep1;
                     rep2_in = dec.rep2;
                     nrep_in = dec.nrep;
                     clr_in  = dec.clr;
                     pend_in = dec.pend;
                     if (dec.led_we) begin
                        led_in = dec.led_val;
                     end
                     if (dec.set_we) begin
                        set_in = dec.set_val;
                     end
                     if (dec.typ_we) begin
                        typ_in = dec.typ_val;
                     end
                     if (dec.scan_we) begin
                        scan_in = dec.scan_val;
                     end
                     if (dec.blink_set) begin
                        blink_in = 1'b1;
                     end
                     if (dec.fill_en) begin
                        fill_in      = dec.fill_val;
                        fill_pend_in = 1'b1;
                     end
                  end
                  ps2kcp_pkg::REQ_BLINK: begin
                     blink_in = 1'b0;
                  end
                  ps2kcp_pkg::REQ_LOOKUP: begin
                     key_ok_in = key_in_range;
                     state_in  = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            kf_in    = key_ok_ff ? ram_rdata : 3'd0;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tvalid && rsp_tready) begin
               idx_in = idx_ff + 2'd1;
               if (last_res) begin
                  idx_in   = 2'd0;
                  state_in = fill_pend_ff ? ST_SWEEP : ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         pend_ff      <= ps2kcp_pkg::PEND_NONE;
         set_ff       <= 2'd1;
         led_ff       <= 3'd0;
         blink_ff     <= 1'b0;
         scan_ff      <= 1'b1;
         typ_ff       <= ps2kcp_pkg::TYP_DEFAULT;
         en_sets_ff   <= 2'd0;
         fill_ff      <= ps2kcp_pkg::FLAGS_ALL;
         fill_pend_ff <= 1'b1;
         sweep_ff     <= '0;
         idx_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         set_ff       <= set_in;
         led_ff       <= led_in;
         blink_ff     <= blink_in;
         scan_ff      <= scan_in;
         typ_ff       <= typ_in;
         en_sets_ff   <= en_sets_in;
         fill_ff      <= fill_in;
         fill_pend_ff <= fill_pend_in;
         sweep_ff     <= sweep_in;
         idx_ff       <= idx_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      key_ok_ff <= key_ok_in;
      rep0_ff   <= rep0_in;
      rep1_ff   <= rep1_in;
      rep2_ff   <= rep2_in;
      nrep_ff   <= nrep_in;
      clr_ff    <= clr_in;
      kf_ff     <= kf_in;
   end

   // pick the reply byte of the current transfer
   always_comb begin
      case (idx_ff)
         2'd0:    reply = rep0_ff;
         2'd1:    reply = rep1_ff;
         default: reply = rep2_ff;
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tuser  = (nrep_ff != 2'd0);
   assign rsp_tlast  = last_res;
   assign rsp_tdata  = {3'd0,
                        kf_ff,
                        ps2kcp_pkg::RATE_TAB[typ_ff[4:0]],
                        ps2kcp_pkg::delay_ms(typ_ff[6:5]),
                        set_ff,
                        blink_ff ? 3'b111 : led_ff,
                        scan_ff,
                        clr_ff,
                        reply};

endmodule

// ----- hdl/ps2kcp_checker.sv -----
`include "assert_macros.svh"

module ps2kcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // a stalled result keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // no new request while results are still going out
   `ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_tvalid, !req_tready, "request taken while results pending")

   // an accepted request closes the input for the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "input still open after a transfer")

   // a transfer without a reply carries a zero byte and is the last one
   `ASSERT_IMP(a_no_reply_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[7:0] == 8'd0 && rsp_tlast, "reply byte set without reply")

   // the selected code set is never zero
   `ASSERT_IMP(a_set_nonzero, clock, reset, rsp_tvalid, rsp_tdata[14:13] != 2'd0, "code set zero")

endmodule

bind ps2_keyboard_command_processor_unit ps2kcp_checker u_ps2kcp_checker (.*);

// ----- verif/ps2_keyboard_command_processor_unit_tb.sv -----
module ps2_keyboard_command_processor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // key table depth as built into the block by default
   localparam int KEY_CODES = ps2kcp_pkg::KEY_CODES_DEF;
   // write sweep through the key table plus some slack
   localparam int SWEEP_PAUSE = KEY_CODES + 40;
   // long receiver hold-off that backs the block up into its input
   localparam int HOLD_CYCLES = 400;

   localparam logic [2:0] ADDR_ENABLED_SETS = 3'd0;
   localparam logic [1:0] REQ_SPARE = 2'd3;      // request kind that changes no setting
   localparam logic [7:0] CMD_UNKNOWN = 8'hef;   // bit 7 set, names no command
   localparam logic [7:0] SET_QUERY = 8'h00;     // code-set parameter that asks
   localparam logic [7:0] STRAY_LOW = 8'h00;

   // typematic tables, lowest entry in the lowest bits
   localparam logic [32*9-1:0] RATE_VALUES = {
      9'd500, 9'd476, 9'd435, 9'd400, 9'd370, 9'd333, 9'd303, 9'd270,
      9'd250, 9'd233, 9'd217, 9'd200, 9'd182, 9'd167, 9'd149, 9'd133,
      9'd125, 9'd118, 9'd109, 9'd100, 9'd92,  9'd83,  9'd75,  9'd67,
      9'd63,  9'd58,  9'd54,  9'd50,  9'd46,  9'd42,  9'd37,  9'd33
   };
   localparam logic [4*10-1:0] DELAY_VALUES = {10'd1000, 10'd750, 10'd500, 10'd250};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } req_item_type;

   // one result transfer as the block should present it
   typedef struct packed {
      logic       vld;
      logic [7:0] rb;
      logic       lst;
      logic       clr;
      logic       scan;
      logic [2:0] leds;
      logic [1:0] cset;
      logic [9:0] dly;
      logic [8:0] ivl;
      logic       mk;
      logic       br;
      logic       rp;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ps2_keyboard_command_processor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectations
   req_item_type pending_reqs[$];
   reply_type    expected_replies[$];
   req_item_type next_req;

   // idle percentages per side, changed only between phases
   int send_idle = 30;
   int recv_idle = 77;

   int items_sent = 0;
   int transfers_seen = 0;
   int replies_seen = 0;
   int mismatches = 0;

   // receiver hold-off
   logic hold_kick = 1'b0;
   int   hold_left = 0;

   // keyboard state as the testbench tracks it
   logic [1:0]           sets_reg;
   ps2kcp_pkg::pend_type waiting_cmd;
   logic [1:0]           cur_set;
   logic [7:0]           led_reg;
   logic                 blink_on;
   logic                 scan_on;
   logic [1:0]           delay_idx;
   logic [4:0]           rate_sel;
   logic [2:0]           key_flags [KEY_CODES];

   // replies gathered while one request is worked out
   logic [7:0] reply_bytes [3];
   int         reply_cnt;
   logic       clear_req;

   logic [7:0] command_set [17];

   task automatic add_reply(input logic [7:0] b);
      if (reply_cnt < 3) begin
         reply_bytes[reply_cnt] = b;
         reply_cnt++;
      end
   endtask

   task automatic fill_keys(input logic [2:0] f);
      for (int i = 0; i < KEY_CODES; i++)
         key_flags[i] = f;
   endtask

   task automatic load_defaults();
      delay_idx = 2'd1;
      rate_sel = 5'd0;
      fill_keys(ps2kcp_pkg::FLAGS_ALL);
      cur_set = sets_reg[0] ? 2'd2 : 2'd1;
      clear_req = 1'b1;
   endtask

   task automatic set_one_key(input logic [7:0] key, input logic [2:0] f);
      add_reply(ps2kcp_pkg::RPL_ACK);
      clear_req = 1'b1;
      if (int'(key) < KEY_CODES)
         key_flags[key] = f;
   endtask

   // parameter byte of a command that was waiting for one
   task automatic take_param(input ps2kcp_pkg::pend_type held, input logic [7:0] p);
      case (held)
         ps2kcp_pkg::PEND_LEDS: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            led_reg = p;
         end
         ps2kcp_pkg::PEND_SET: begin
            if (p == SET_QUERY) begin
               add_reply(ps2kcp_pkg::RPL_ACK);
               add_reply({6'd0, cur_set});
            end else if (p > 8'd3 || (p == 8'd2 && !sets_reg[0]) ||
                         (p == 8'd3 && !sets_reg[1])) begin
               // refused set keeps the command waiting for a retry
               waiting_cmd = ps2kcp_pkg::PEND_SET;
               add_reply(ps2kcp_pkg::RPL_RESEND);
            end else begin
               cur_set = p[1:0];
               clear_req = 1'b1;
               add_reply(ps2kcp_pkg::RPL_ACK);
            end
         end
         ps2kcp_pkg::PEND_RATE: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            delay_idx = p[6:5];
            rate_sel = p[4:0];
         end
         ps2kcp_pkg::PEND_KTYPE: set_one_key(p, ps2kcp_pkg::FLAGS_TYPE);
         ps2kcp_pkg::PEND_KMB:   set_one_key(p, ps2kcp_pkg::FLAGS_MB);
         ps2kcp_pkg::PEND_KMO:   set_one_key(p, ps2kcp_pkg::FLAGS_MO);
         default: ;
      endcase
   endtask

   task automatic take_command(input logic [7:0] c);
      case (c)
         ps2kcp_pkg::CMD_SET_LEDS: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            waiting_cmd = ps2kcp_pkg::PEND_LEDS;
         end
         ps2kcp_pkg::CMD_TYPEMATIC: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            waiting_cmd = ps2kcp_pkg::PEND_RATE;
         end
         ps2kcp_pkg::CMD_CODE_SET: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            waiting_cmd = ps2kcp_pkg::PEND_SET;
         end
         ps2kcp_pkg::CMD_KEY_TYPE: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            waiting_cmd = ps2kcp_pkg::PEND_KTYPE;
         end
         ps2kcp_pkg::CMD_KEY_MB: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            waiting_cmd = ps2kcp_pkg::PEND_KMB;
         end
         ps2kcp_pkg::CMD_KEY_MO: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            waiting_cmd = ps2kcp_pkg::PEND_KMO;
         end
         ps2kcp_pkg::CMD_ECHO: add_reply(ps2kcp_pkg::RPL_ECHO);
         ps2kcp_pkg::CMD_READ_ID: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            add_reply(ps2kcp_pkg::RPL_ID0);
            add_reply(ps2kcp_pkg::RPL_ID1);
         end
         ps2kcp_pkg::CMD_ENABLE: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            scan_on = 1'b1;
         end
         ps2kcp_pkg::CMD_DISABLE: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            load_defaults();
            scan_on = 1'b0;
         end
         ps2kcp_pkg::CMD_DEFAULTS: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            load_defaults();
            scan_on = 1'b1;
         end
         ps2kcp_pkg::CMD_ALL_TYPE: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            fill_keys(ps2kcp_pkg::FLAGS_TYPE);
         end
         ps2kcp_pkg::CMD_ALL_MB: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            fill_keys(ps2kcp_pkg::FLAGS_MB);
         end
         ps2kcp_pkg::CMD_ALL_MO: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            fill_keys(ps2kcp_pkg::FLAGS_MO);
         end
         ps2kcp_pkg::CMD_ALL_MBT: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            clear_req = 1'b1;
            fill_keys(ps2kcp_pkg::FLAGS_ALL);
         end
         ps2kcp_pkg::CMD_RESEND: add_reply(ps2kcp_pkg::RPL_ACK);
         ps2kcp_pkg::CMD_RESET: begin
            add_reply(ps2kcp_pkg::RPL_ACK);
            load_defaults();
            scan_on = 1'b1;
            led_reg = 8'h00;
            blink_on = 1'b1;
            add_reply(ps2kcp_pkg::RPL_BAT_OK);
         end
         default: add_reply(ps2kcp_pkg::RPL_RESEND);
      endcase
   endtask

   // works out the transfers that one accepted request must produce
   task automatic keyboard_respond(input logic [1:0] kind, input logic [7:0] b);
      logic                 is_cmd;
      ps2kcp_pkg::pend_type held;
      logic [2:0]           kf;
      reply_type            r;
      int                   n;
      reply_cnt = 0;
      clear_req = 1'b0;
      kf = 3'b000;
      if (kind == ps2kcp_pkg::REQ_HOST) begin
         // per-key commands take any byte as their key code
         is_cmd = b[7] && waiting_cmd != ps2kcp_pkg::PEND_KTYPE &&
                  waiting_cmd != ps2kcp_pkg::PEND_KMB &&
                  waiting_cmd != ps2kcp_pkg::PEND_KMO;
         if (is_cmd)
            waiting_cmd = ps2kcp_pkg::PEND_NONE;
         held = waiting_cmd;
         if (held != ps2kcp_pkg::PEND_NONE) begin
            waiting_cmd = ps2kcp_pkg::PEND_NONE;
            take_param(held, b);
         end else if (is_cmd) begin
            take_command(b);
         end
      end else if (kind == ps2kcp_pkg::REQ_BLINK) begin
         blink_on = 1'b0;
      end else if (kind == ps2kcp_pkg::REQ_LOOKUP) begin
         if (int'(b) < KEY_CODES)
            kf = key_flags[b];
      end
      n = (reply_cnt != 0) ? reply_cnt : 1;
      for (int k = 0; k < n; k++) begin
         r.vld = (reply_cnt != 0);
         r.rb = r.vld ? reply_bytes[k] : 8'h00;
         r.lst = (k == n - 1);
         r.clr = clear_req;
         r.scan = scan_on;
         r.leds = blink_on ? 3'b111 : led_reg[2:0];
         r.cset = cur_set;
         r.dly = DELAY_VALUES[delay_idx*10 +: 10];
         r.ivl = RATE_VALUES[rate_sel*9 +: 9];
         r.mk = kf[0];
         r.br = kf[1];
         r.rp = kf[2];
         expected_replies.push_back(r);
      end
   endtask

   // one line per mismatch, counted
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("ERROR transfer %0d: %s is %0h, expected %0h",
               transfers_seen, what, got, want);
   endtask

   task automatic check_transfer();
      reply_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch("unexpected transfer, reply_byte", rsp_tdata[7:0], 0);
      end else begin
         want = expected_replies.pop_front();
         if (rsp_tuser !== want.vld) report_mismatch("reply_valid", rsp_tuser, want.vld);
         if (rsp_tdata[7:0] !== want.rb) report_mismatch("reply_byte", rsp_tdata[7:0], want.rb);
         if (rsp_tlast !== want.lst) report_mismatch("last", rsp_tlast, want.lst);
         if (rsp_tdata[8] !== want.clr) report_mismatch("buffer_clear", rsp_tdata[8], want.clr);
         if (rsp_tdata[9] !== want.scan) report_mismatch("scanning", rsp_tdata[9], want.scan);
         if (rsp_tdata[12:10] !== want.leds)
            report_mismatch("led_bits", rsp_tdata[12:10], want.leds);
         if (rsp_tdata[14:13] !== want.cset)
            report_mismatch("active_set", rsp_tdata[14:13], want.cset);
         if (rsp_tdata[24:15] !== want.dly)
            report_mismatch("typematic_delay_ms", rsp_tdata[24:15], want.dly);
         if (rsp_tdata[33:25] !== want.ivl)
            report_mismatch("typematic_interval", rsp_tdata[33:25], want.ivl);
         if (rsp_tdata[34] !== want.mk) report_mismatch("key_make_on", rsp_tdata[34], want.mk);
         if (rsp_tdata[35] !== want.br) report_mismatch("key_break_on", rsp_tdata[35], want.br);
         if (rsp_tdata[36] !== want.rp)
            report_mismatch("key_repeat_on", rsp_tdata[36], want.rp);
         if (rsp_tdata[39:37] !== 3'b000)
            report_mismatch("tdata pad bits", rsp_tdata[39:37], 0);
         if (want.vld)
            replies_seen++;
      end
      transfers_seen++;
   endtask

   // request driver: holds an offered item until its transfer, then maybe idles
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            keyboard_respond(req_tuser, req_tdata);
            items_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // keep offering the same item
         end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
            next_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_req.kind;
            req_tdata <= next_req.data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long hold-off counter, started by a one-cycle kick
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor: random backpressure and a check of every transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
         if (rsp_tvalid && rsp_tready)
            check_transfer();
      end
   end

   task automatic push_req(input logic [1:0] kind, input logic [7:0] b);
      req_item_type it;
      it.kind = kind;
      it.data = b;
      pending_reqs.push_back(it);
   endtask

   // apb write of enabled_sets: setup cycle, then access cycle
   task automatic write_enabled_sets(input logic [1:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_ENABLED_SETS;
      csr_pwdata <= {30'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sets_reg = v;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // waits until every queued item went out and every result came back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(negedge clock);
      // an all-keys sweep may still run after its last transfer
      repeat (SWEEP_PAUSE) @(negedge clock);
   endtask

   // mostly well-formed command sequences with random content, some noise
   task automatic add_random_reqs(input int count);
      int         start;
      int         pick;
      logic [7:0] c;
      logic [7:0] p;
      start = pending_reqs.size();
      while (pending_reqs.size() - start < count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            case ($urandom_range(4))
               0: push_req(ps2kcp_pkg::REQ_HOST, 8'($urandom_range(127)));  // stray parameter
               1: push_req(ps2kcp_pkg::REQ_HOST, 8'($urandom_range(255)));
               2: push_req(REQ_SPARE, 8'($urandom_range(255)));
               3: push_req(ps2kcp_pkg::REQ_HOST, 8'h80 | 8'($urandom_range(127)));
               default: push_req(ps2kcp_pkg::REQ_BLINK, 8'($urandom_range(255)));
            endcase
         end else if (pick < 30) begin
            push_req(ps2kcp_pkg::REQ_LOOKUP, 8'($urandom_range(255)));
         end else if (pick < 35) begin
            push_req(ps2kcp_pkg::REQ_BLINK, 8'($urandom_range(255)));
         end else begin
            c = command_set[$urandom_range(16)];
            push_req(ps2kcp_pkg::REQ_HOST, c);
            // now and then the parameter is dropped to break the sequence
            if ($urandom_range(9) != 0) begin
               case (c)
                  ps2kcp_pkg::CMD_SET_LEDS, ps2kcp_pkg::CMD_TYPEMATIC:
                     push_req(ps2kcp_pkg::REQ_HOST, 8'($urandom_range(127)));
                  ps2kcp_pkg::CMD_CODE_SET: begin
                     p = ($urandom_range(9) < 7) ? 8'($urandom_range(3))
                                                 : 8'($urandom_range(127, 4));
                     push_req(ps2kcp_pkg::REQ_HOST, p);
                     // retry after a possible refusal
                     if ($urandom_range(1) == 1)
                        push_req(ps2kcp_pkg::REQ_HOST, 8'($urandom_range(3)));
                  end
                  ps2kcp_pkg::CMD_KEY_TYPE, ps2kcp_pkg::CMD_KEY_MB,
                  ps2kcp_pkg::CMD_KEY_MO: begin
                     p = 8'($urandom_range(255));
                     push_req(ps2kcp_pkg::REQ_HOST, p);
                     if ($urandom_range(9) < 4)
                        push_req(ps2kcp_pkg::REQ_LOOKUP, p);
                  end
                  default: ;
               endcase
            end
         end
      end
   endtask

   initial begin
      int base;

      command_set = '{ps2kcp_pkg::CMD_SET_LEDS, ps2kcp_pkg::CMD_ECHO,
                      ps2kcp_pkg::CMD_CODE_SET, ps2kcp_pkg::CMD_READ_ID,
                      ps2kcp_pkg::CMD_TYPEMATIC, ps2kcp_pkg::CMD_ENABLE,
                      ps2kcp_pkg::CMD_DISABLE, ps2kcp_pkg::CMD_DEFAULTS,
                      ps2kcp_pkg::CMD_ALL_TYPE, ps2kcp_pkg::CMD_ALL_MB,
                      ps2kcp_pkg::CMD_ALL_MO, ps2kcp_pkg::CMD_ALL_MBT,
                      ps2kcp_pkg::CMD_KEY_TYPE, ps2kcp_pkg::CMD_KEY_MB,
                      ps2kcp_pkg::CMD_KEY_MO, ps2kcp_pkg::CMD_RESEND,
                      ps2kcp_pkg::CMD_RESET};

      // keyboard state after reset
      sets_reg = 2'd0;
      waiting_cmd = ps2kcp_pkg::PEND_NONE;
      cur_set = 2'd1;
      led_reg = 8'h00;
      blink_on = 1'b0;
      scan_on = 1'b1;
      delay_idx = 2'd1;
      rate_sel = 5'd0;
      fill_keys(ps2kcp_pkg::FLAGS_ALL);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // the block loads its key table before it takes a request
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);

      // directed part, no code set enabled
      write_enabled_sets(2'd0);
      push_req(ps2kcp_pkg::REQ_HOST, STRAY_LOW);          // parameter with nothing waiting
      push_req(ps2kcp_pkg::REQ_LOOKUP, 8'h00);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_SET_LEDS);
      push_req(ps2kcp_pkg::REQ_HOST, 8'h7f);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_TYPEMATIC);
      push_req(ps2kcp_pkg::REQ_HOST, 8'h7f);              // slowest delay, slowest rate
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_CODE_SET);
      push_req(ps2kcp_pkg::REQ_HOST, 8'h02);              // refused, stays waiting
      push_req(ps2kcp_pkg::REQ_HOST, 8'h7f);              // out of range, refused
      push_req(ps2kcp_pkg::REQ_HOST, SET_QUERY);          // ack then the current set
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_SET_LEDS);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_ECHO);  // drops the waiting one
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_READ_ID);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_KEY_TYPE);
      push_req(ps2kcp_pkg::REQ_HOST, 8'hff);              // key code with bit 7 set
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_KEY_MO);
      push_req(ps2kcp_pkg::REQ_HOST, 8'h80);
      push_req(ps2kcp_pkg::REQ_LOOKUP, 8'hff);
      push_req(ps2kcp_pkg::REQ_LOOKUP, 8'h80);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_ALL_MB);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_DISABLE);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_ENABLE);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_RESET);  // leds on until blink expiry
      push_req(ps2kcp_pkg::REQ_BLINK, 8'hff);
      push_req(REQ_SPARE, 8'h00);                         // unused request kind
      push_req(ps2kcp_pkg::REQ_HOST, CMD_UNKNOWN);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_RESEND);
      drain();

      // random phase 1: both code sets allowed, receiver mostly stalled
      write_enabled_sets(2'd3);
      // per-key, all-keys and defaults commands not yet used above
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_KEY_MB);
      push_req(ps2kcp_pkg::REQ_HOST, 8'h00);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_ALL_TYPE);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_ALL_MO);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_ALL_MBT);
      push_req(ps2kcp_pkg::REQ_HOST, ps2kcp_pkg::CMD_DEFAULTS);
      add_random_reqs(80);
      drain();

      // random phase 2: set 2 only, sender mostly idle
      send_idle = 77;
      recv_idle = 30;
      write_enabled_sets(2'd1);
      add_random_reqs(80);
      drain();

      // random phase 3: set 3 only, no idling, one long receiver hold-off
      send_idle = 0;
      recv_idle = 0;
      write_enabled_sets(2'd2);
      base = items_sent;
      add_random_reqs(75);
      while (items_sent < base + 30)
         @(negedge clock);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      drain();

      $display("covered %0d requests, %0d result transfers and %0d reply bytes",
               items_sent, transfers_seen, replies_seen);
      $display("code-set masks 0, 3, 1 and 2 with uneven and absent idling on both sides");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d transfers still expected", expected_replies.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
